// File: src/cs_pkg.sv
// Shared types and constants of the cosine similarity block.
// No dependencies; every other file imports this package.
package cs_pkg;

   localparam int ELEM_W = 16;
   localparam int SUM_W  = 48;
   localparam int LIMB_W = 32;
   localparam int PROD_W = 64;
   localparam int WIDE_W = 96;
   localparam int ACC_W  = 128;
   localparam int BIT_W  = 4;
   localparam int CNT_W  = 3;

   localparam logic [ELEM_W-1:0] K_FULL  = 16'h8000;
   localparam logic [ELEM_W-1:0] SIM_MAX = 16'h7FFF;
   localparam logic [BIT_W-1:0]  BIT_TOP = 4'd15;

   localparam logic [CNT_W-1:0] N_NORM = 3'd4;
   localparam logic [CNT_W-1:0] N_MAG  = 3'd4;
   localparam logic [CNT_W-1:0] N_SQR  = 3'd1;
   localparam logic [CNT_W-1:0] N_LHS  = 3'd3;

   typedef enum logic [1:0] {
      PH_NORM = 2'd0,
      PH_MAG  = 2'd1,
      PH_SQR  = 2'd2,
      PH_LHS  = 2'd3
   } phase_type;

   typedef struct packed {
      logic             in_fire;
      logic             in_last;
      logic             clr_acc;
      logic             mul_en;
      phase_type        phase;
      logic [1:0]       idx;
      logic             wb;
      logic [BIT_W-1:0] bit_sel;
      logic             load_out;
   } cmd_type;

   typedef struct packed {
      logic skip;
   } status_type;

endpackage

// File: src/cs_if.sv
// Request and response channel interfaces of the cosine similarity block.
// Depends on cs_pkg for field widths.
interface cs_req_if import cs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] elem_a;
   logic signed [ELEM_W-1:0] elem_b;
   logic                     last_pair;

   modport source (output valid, elem_a, elem_b, last_pair, input ready);
   modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface cs_rsp_if import cs_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] similarity;

   modport source (output valid, similarity, input ready);
   modport sink   (input valid, similarity, output ready);
endinterface

// File: src/cs_ctrl.sv
// Sequencer of the cosine similarity block: phases, limb steps, bit search.
// Depends on cs_pkg; drives cs_dpath through cmd_type.
module cs_ctrl import cs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output cmd_type    cmd,
   input  status_type status
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_NORM   = 6'b000010,
      S_MAG    = 6'b000100,
      S_SQR    = 6'b001000,
      S_LHS    = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [BIT_W-1:0] bit_ff, bit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] n_ops;
   logic             busy;

   always_comb begin
      case (state_ff)
         S_NORM:  n_ops = N_NORM;
         S_MAG:   n_ops = N_MAG;
         S_SQR:   n_ops = N_SQR;
         S_LHS:   n_ops = N_LHS;
         default: n_ops = '0;
      endcase
   end

   assign busy = (state_ff == S_NORM) || (state_ff == S_MAG) ||
                 (state_ff == S_SQR)  || (state_ff == S_LHS);

   always_comb begin
      cmd          = '0;
      cmd.in_fire  = req_valid && req_ready;
      cmd.in_last  = req_last;
      cmd.idx      = cnt_ff[1:0];
      cmd.bit_sel  = bit_ff;
      cmd.clr_acc  = busy && (cnt_ff == '0);
      cmd.mul_en   = busy && (cnt_ff < n_ops);
      cmd.wb       = busy && (cnt_ff == n_ops + 3'd1);
      case (state_ff)
         S_MAG:   cmd.phase = PH_MAG;
         S_SQR:   cmd.phase = PH_SQR;
         S_LHS:   cmd.phase = PH_LHS;
         default: cmd.phase = PH_NORM;
      endcase
      if (state_ff == S_SQR && status.skip) begin
         cmd.wb = 1'b0;
      end
      cmd.load_out = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = busy ? cnt_ff + 3'd1 : '0;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_last) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (cmd.wb) begin
               state_in = S_MAG;
               cnt_in   = '0;
            end
         end
         S_MAG: begin
            if (cmd.wb) begin
               state_in = S_SQR;
               cnt_in   = '0;
               bit_in   = BIT_TOP;
            end
         end
         S_SQR: begin
            if (status.skip) begin
               cnt_in = '0;
               if (bit_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  bit_in = bit_ff - 4'd1;
               end
            end else if (cmd.wb) begin
               state_in = S_LHS;
               cnt_in   = '0;
            end
         end
         S_LHS: begin
            if (cmd.wb) begin
               cnt_in = '0;
               if (bit_ff == '0) begin
                  state_in = S_FINISH;
               end else begin
                  bit_in   = bit_ff - 4'd1;
                  state_in = S_SQR;
               end
            end
         end
         S_FINISH: begin
            if (cmd.load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         bit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bit_ff       <= bit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (state_ff == S_NORM))
      else $error("last pair transfer did not start the norm phase");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken result");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy |-> (cnt_ff <= n_ops + 3'd1))
      else $error("step counter ran past its phase");
`endif

endmodule

// File: src/cs_dpath.sv
// Datapath: running sums, shared 32x32 multiplier with 128-bit accumulator,
// root-free bit search of the result. Depends on cs_pkg.
module cs_dpath import cs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic signed [ELEM_W-1:0] elem_a,
   input  logic signed [ELEM_W-1:0] elem_b,
   output logic signed [ELEM_W-1:0] similarity
);

   logic [SUM_W-1:0]  dot_ff, na_ff, nb_ff;
   logic [SUM_W-1:0]  dotc_ff, nac_ff, nbc_ff, mag_ff;
   logic [WIDE_W-1:0] p_ff, m_ff;
   logic [LIMB_W-1:0] s_ff;
   logic [ELEM_W-1:0] k_ff, sim_ff;
   logic [ACC_W-1:0]  acc_ff, acc_add;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]        sh_ff, sh_in;
   logic              vld_ff;
   logic signed [2*ELEM_W-1:0] ab, aa, bb;
   logic [SUM_W-1:0]  dot_new, na_new, nb_new;
   logic [ELEM_W-1:0] t, tm1, d;
   logic [LIMB_W-1:0] opa, opb;
   logic              zero_norm;

   assign ab = elem_a * elem_b;
   assign aa = elem_a * elem_a;
   assign bb = elem_b * elem_b;
   assign dot_new = dot_ff + {{(SUM_W-2*ELEM_W){ab[2*ELEM_W-1]}}, ab};
   assign na_new  = na_ff + {{(SUM_W-2*ELEM_W){1'b0}}, aa};
   assign nb_new  = nb_ff + {{(SUM_W-2*ELEM_W){1'b0}}, bb};

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff <= '0;
         na_ff  <= '0;
         nb_ff  <= '0;
      end else if (cmd.in_fire) begin
         if (cmd.in_last) begin
            dot_ff <= '0;
            na_ff  <= '0;
            nb_ff  <= '0;
         end else begin
            dot_ff <= dot_new;
            na_ff  <= na_new;
            nb_ff  <= nb_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_fire && cmd.in_last) begin
         dotc_ff <= dot_new;
         nac_ff  <= na_new;
         nbc_ff  <= nb_new;
      end
   end

   assign t   = k_ff | (16'd1 << cmd.bit_sel);
   assign tm1 = t - 16'd1;
   assign d   = {tm1[ELEM_W-2:0], 1'b1};
   assign status.skip = (t > K_FULL);

   always_comb begin
      opa   = '0;
      opb   = '0;
      sh_in = '0;
      case (cmd.phase)
         PH_NORM: begin
            opa   = cmd.idx[1] ? LIMB_W'(nac_ff[SUM_W-1:LIMB_W]) : nac_ff[LIMB_W-1:0];
            opb   = cmd.idx[0] ? LIMB_W'(nbc_ff[SUM_W-1:LIMB_W]) : nbc_ff[LIMB_W-1:0];
            sh_in = {1'b0, cmd.idx[1]} + {1'b0, cmd.idx[0]};
         end
         PH_MAG: begin
            opa   = cmd.idx[1] ? LIMB_W'(mag_ff[SUM_W-1:LIMB_W]) : mag_ff[LIMB_W-1:0];
            opb   = cmd.idx[0] ? LIMB_W'(mag_ff[SUM_W-1:LIMB_W]) : mag_ff[LIMB_W-1:0];
            sh_in = {1'b0, cmd.idx[1]} + {1'b0, cmd.idx[0]};
         end
         PH_SQR: begin
            opa = LIMB_W'(d);
            opb = LIMB_W'(d);
         end
         PH_LHS: begin
            case (cmd.idx)
               2'd0:    opa = p_ff[LIMB_W-1:0];
               2'd1:    opa = p_ff[2*LIMB_W-1:LIMB_W];
               2'd2:    opa = p_ff[3*LIMB_W-1:2*LIMB_W];
               default: opa = '0;
            endcase
            opb   = s_ff;
            sh_in = cmd.idx;
         end
         default: begin
            opa = '0;
         end
      endcase
   end

   assign prod_in = {32'b0, opa} * {32'b0, opb};

   always_comb begin
      case (sh_ff)
         2'd0:    acc_add = {64'b0, prod_ff};
         2'd1:    acc_add = {32'b0, prod_ff, 32'b0};
         2'd2:    acc_add = {prod_ff, 64'b0};
         default: acc_add = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sh_ff   <= sh_in;
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= cmd.mul_en;
      end
      if (cmd.clr_acc) begin
         acc_ff <= '0;
      end else if (vld_ff) begin
         acc_ff <= acc_ff + acc_add;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.in_fire && cmd.in_last) begin
         k_ff <= '0;
      end else if (cmd.wb) begin
         case (cmd.phase)
            PH_NORM: begin
               p_ff   <= acc_ff[WIDE_W-1:0];
               mag_ff <= dotc_ff[SUM_W-1] ? (~dotc_ff) + 48'd1 : dotc_ff;
            end
            PH_MAG:  m_ff <= acc_ff[WIDE_W-1:0];
            PH_SQR:  s_ff <= acc_ff[LIMB_W-1:0];
            PH_LHS: begin
               if (acc_ff <= {m_ff, 32'b0}) begin
                  k_ff <= t;
               end
            end
            default: s_ff <= s_ff;
         endcase
      end
   end

   assign zero_norm = (nac_ff == '0) || (nbc_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         if (zero_norm) begin
            sim_ff <= '0;
         end else if (dotc_ff[SUM_W-1]) begin
            sim_ff <= (~k_ff) + 16'd1;
         end else if (k_ff[ELEM_W-1]) begin
            sim_ff <= SIM_MAX;
         end else begin
            sim_ff <= k_ff;
         end
      end
   end

   assign similarity = sim_ff;

endmodule

// File: src/cosine_similarity.sv
// Top level of the cosine similarity block: ties sequencer and datapath to
// the channels. Depends on cs_pkg, cs_if, cs_ctrl and cs_dpath.
//
//   channel   direction   fields
//   req_if    in          elem_a, elem_b, last_pair
//   rsp_if    out         similarity
//
// A pair without last_pair is taken while the block is idle and added to the running sums.
// A last pair starts the work: two 4-step 96-bit products on
// the shared 32x32 multiplier, then 16 bit steps of a square and a compare
// each (a bit that cannot be set is passed over without them). No pair is taken during that work.
// A finished result waits in the output register; the next vector may stream in.
// Synchronous reset clears the sums and the control state.
module cosine_similarity import cs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cs_req_if.sink   req_if,
   cs_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   cs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_pair),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   cs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .elem_a     (req_if.elem_a),
      .elem_b     (req_if.elem_b),
      .similarity (rsp_if.similarity)
   );

endmodule
